>>> rtl/xat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xat_pkg
// Shared constants and types for the start-tag attribute tokenizer.
// ----------------------------------------------------------------------------
package xat_pkg;

	localparam int unsigned MaxTagBytes = 4096;
	localparam int unsigned PosW        = 12;

	typedef logic [PosW-1:0] pos_t;

	localparam pos_t PosCap = ((MaxTagBytes - 1) < 4095) ? PosW'(MaxTagBytes - 1)
	                                                       : PosW'(4095);

	localparam logic [7:0] ChGt    = 8'h3E;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChEq    = 8'h3D;
	localparam logic [7:0] ChDq    = 8'h22;
	localparam logic [7:0] ChSq    = 8'h27;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSp    = 8'h20;

	localparam logic [2:0] PhFirst = 3'd0;
	localparam logic [2:0] PhElem  = 3'd1;
	localparam logic [2:0] PhGap   = 3'd2;
	localparam logic [2:0] PhName  = 3'd3;
	localparam logic [2:0] PhEq    = 3'd4;
	localparam logic [2:0] PhValue = 3'd5;
	localparam logic [2:0] PhDone  = 3'd6;

	localparam logic KindAttr = 1'b0;
	localparam logic KindEnd  = 1'b1;

	typedef struct packed {
		logic item_kind;
		pos_t name_begin;
		pos_t name_stop;
		pos_t value_begin;
		pos_t value_stop;
		logic size_overflow;
		logic run_last;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/xat_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xat_scan
// Per-byte tag scanner: tracks phase and offsets, forms up to two results.
// ----------------------------------------------------------------------------
module xat_scan (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               take,
	input  wire  [7:0]        tag_byte,
	input  wire               tag_last,
	output logic [1:0]        push_n,
	output xat_pkg::res_t     res_a,
	output xat_pkg::res_t     res_b
);
	import xat_pkg::*;

	logic [2:0] phase_q, phase_d;
	pos_t       pos_q, pos_d;
	pos_t       nstart_q, nstart_d;
	pos_t       nend_q, nend_d;
	pos_t       vstart_q, vstart_d;
	logic       qsingle_q, qsingle_d;
	logic       ovf_q, ovf_d;
	logic       cap_q, cap_d;

	pos_t       p;
	logic       is_sp;
	logic       is_stop;
	logic       emit;
	res_t       attr;
	res_t       mark;

	always_comb begin
		p       = cap_q ? PosCap : pos_q;
		ovf_d   = ovf_q | cap_q;
		is_sp   = tag_byte inside {ChSp, ChTab, ChLf, ChCr};
		is_stop = (tag_byte == ChGt) || (tag_byte == ChSlash);
		phase_d   = phase_q;
		nstart_d  = nstart_q;
		nend_d    = nend_q;
		vstart_d  = vstart_q;
		qsingle_d = qsingle_q;
		emit      = 1'b0;

		case (phase_q)
			PhFirst: phase_d = PhElem;
			PhElem: begin
				if (is_stop) phase_d = PhDone;
				else if (is_sp) phase_d = PhGap;
			end
			PhGap: begin
				if (is_stop) begin
					phase_d = PhDone;
				end else if (!is_sp) begin
					nstart_d = p;
					if (tag_byte == ChEq) begin
						nend_d  = p;
						phase_d = PhEq;
					end else begin
						phase_d = PhName;
					end
				end
			end
			PhName: begin
				if (tag_byte == ChEq) begin
					nend_d  = p;
					phase_d = PhEq;
				end else if (tag_byte == ChGt || is_sp) begin
					nend_d  = p;
					phase_d = PhGap;
				end
			end
			PhEq: begin
				if (tag_byte == ChDq || tag_byte == ChSq) begin
					qsingle_d = (tag_byte == ChSq);
					vstart_d  = (p < PosCap) ? pos_t'(p + pos_t'(1)) : PosCap;
					phase_d   = PhValue;
				end else begin
					phase_d = PhGap;
				end
			end
			PhValue: begin
				if (tag_byte == (qsingle_q ? ChSq : ChDq)) begin
					emit    = (nend_q > nstart_q);
					phase_d = PhGap;
				end
			end
			default: phase_d = phase_q;
		endcase

		cap_d = cap_q;
		pos_d = pos_q;
		if (p >= PosCap) cap_d = 1'b1;
		else pos_d = pos_t'(p + pos_t'(1));

		attr = '{item_kind: KindAttr, name_begin: nstart_q, name_stop: nend_q,
		         value_begin: vstart_q, value_stop: p, size_overflow: ovf_d,
		         run_last: 1'b0};
		mark = '{item_kind: KindEnd, name_begin: '0, name_stop: '0,
		         value_begin: '0, value_stop: '0, size_overflow: ovf_d,
		         run_last: 1'b1};

		res_a  = emit ? attr : mark;
		res_b  = mark;
		push_n = take ? (2'(emit) + 2'(tag_last)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PhFirst;
			pos_q     <= '0;
			nstart_q  <= '0;
			nend_q    <= '0;
			vstart_q  <= '0;
			qsingle_q <= 1'b0;
			ovf_q     <= 1'b0;
			cap_q     <= 1'b0;
		end else if (take) begin
			if (tag_last) begin
				phase_q   <= PhFirst;
				pos_q     <= '0;
				nstart_q  <= '0;
				nend_q    <= '0;
				vstart_q  <= '0;
				qsingle_q <= 1'b0;
				ovf_q     <= 1'b0;
				cap_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				nstart_q  <= nstart_d;
				nend_q    <= nend_d;
				vstart_q  <= vstart_d;
				qsingle_q <= qsingle_d;
				ovf_q     <= ovf_d;
				cap_q     <= cap_d;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/xat_res_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xat_res_queue
// Four-entry result queue: takes up to two results a cycle, releases one.
// ----------------------------------------------------------------------------
module xat_res_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [1:0]        push_n,
	input  wire xat_pkg::res_t wdata_a,
	input  wire xat_pkg::res_t wdata_b,
	output logic              room,
	output logic              head_valid,
	input  wire               head_ready,
	output xat_pkg::res_t     head
);
	import xat_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign room       = (count_q <= 3'd2);
	assign head_valid = (count_q != 3'd0);
	assign head       = mem_q[rd_ptr_q];
	assign pop        = head_valid & head_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= wdata_a;
		if (push_n == 2'd2) mem_q[2'(wr_ptr_q + 2'd1)] <= wdata_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= 2'(wr_ptr_q + push_n);
			if (pop) rd_ptr_q <= 2'(rd_ptr_q + 2'd1);
			count_q <= 3'(count_q + 3'(push_n) - 3'(pop));
		end
	end

endmodule
`default_nettype wire

>>> rtl/xml_attribute_tokenizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xml_attribute_tokenizer_core
// Streams one XML start tag a byte per transaction and reports the offsets of
// each quoted attribute with a non-empty name, then an end-of-tag marker.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue has room. Each byte updates
// the scan state and pushes zero, one or two results (an attribute on its
// closing quote, the end marker on the last byte) into a four-entry result
// queue that drains one result per cycle while out_ready is high. Input is
// held off only while the queue has fewer than two free entries, so the
// sustained rate is one byte per cycle as long as results are taken.
// Offsets saturate at the tag size limit with size_overflow set.
module xml_attribute_tokenizer_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [7:0]         tag_byte,
	input  wire                tag_last,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               item_kind,
	output xat_pkg::pos_t      name_begin,
	output xat_pkg::pos_t      name_stop,
	output xat_pkg::pos_t      value_begin,
	output xat_pkg::pos_t      value_stop,
	output logic               size_overflow,
	output logic               run_last
);
	import xat_pkg::*;

	logic       take;
	logic [1:0] push_n;
	res_t       res_a;
	res_t       res_b;
	res_t       head;

	assign take = in_valid & in_ready;

	xat_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.tag_byte (tag_byte),
		.tag_last (tag_last),
		.push_n   (push_n),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	xat_res_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.wdata_a    (res_a),
		.wdata_b    (res_b),
		.room       (in_ready),
		.head_valid (out_valid),
		.head_ready (out_ready),
		.head       (head)
	);

	assign item_kind     = head.item_kind;
	assign name_begin    = head.name_begin;
	assign name_stop     = head.name_stop;
	assign value_begin   = head.value_begin;
	assign value_stop    = head.value_stop;
	assign size_overflow = head.size_overflow;
	assign run_last      = head.run_last;

endmodule
`default_nettype wire
